[hdl/sse_pkg.sv]
// sse_pkg: shared constants, codes and types of the semaphore set batch engine.
// Depends on nothing; the engine and sse_alu refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package sse_pkg;

	localparam int SET_SIZE      = 16;
	localparam int JOURNAL_DEPTH = 16;

	localparam int IDX_W   = 4;   // sem_index field width
	localparam int VAL_W   = 15;  // counter width
	localparam int OPV_W   = 16;  // op_value field width
	localparam int CFG_W   = 5;   // active_count width
	localparam int JIDX_W  = $clog2(JOURNAL_DEPTH);
	localparam int JFILL_W = $clog2(JOURNAL_DEPTH) + 1;
	localparam int JE_W    = IDX_W + OPV_W;

	localparam logic [VAL_W-1:0]   COUNTER_MAX = {VAL_W{1'b1}};
	localparam logic [IDX_W:0]     SET_LIMIT   = (IDX_W+1)'(SET_SIZE);
	localparam logic [JFILL_W-1:0] FILL_LIMIT  = JFILL_W'(JOURNAL_DEPTH - 1);
	localparam logic [CFG_W-1:0]   ACTIVE_RST  = CFG_W'(16);

	localparam logic [1:0] MODE_OP  = 2'd0;
	localparam logic [1:0] MODE_SET = 2'd1;
	localparam logic [1:0] MODE_GET = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_WOULD_BLOCK = 3'd1;
	localparam logic [2:0] ST_OVERFLOW    = 3'd2;
	localparam logic [2:0] ST_BAD_INDEX   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG    = 3'd4;
	localparam logic [2:0] ST_NEG_SET     = 3'd5;
	localparam logic [2:0] ST_SKIPPED     = 3'd6;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_EXEC    = 5'b00010,
		S_UNDO_RD = 5'b00100,
		S_UNDO_WB = 5'b01000,
		S_FIN     = 5'b10000
	} state_t;

	// flags and clamped sum from the shared adder
	typedef struct packed {
		logic             under;
		logic             over;
		logic [VAL_W-1:0] sat;
	} alu_res_t;

endpackage
`default_nettype wire

[hdl/semaphore_set_batch_engine.sv]
// Semaphore set batch engine: 16 counters, batched ops with journal-based undo.
// Get, set and passing ops: latched item, EXEC, output register (FIN if the slot is busy).
// A failing op with k >= 1 journaled ops first walks UNDO_RD, UNDO_WB per entry, then FIN.
// The sequencer holds one item at a time; in_ready is high only in IDLE.
// Reset (arst_n low, async): counters zero, journal empty, no failed batch,
// active_count 16. Journal RAM content is not cleared and needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module semaphore_set_batch_engine (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration: active_count
	input  wire logic                             cfg_we,
	input  wire logic [sse_pkg::CFG_W-1:0]        cfg_wdata,
	// item input
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       mode,
	input  wire logic [sse_pkg::IDX_W-1:0]        sem_index,
	input  wire logic signed [sse_pkg::OPV_W-1:0] op_value,
	input  wire logic                             last_of_batch,
	// result output
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [2:0]                            status,
	output logic [sse_pkg::VAL_W-1:0]             value,
	output logic                                  batch_done
);

	// ---------------------------------------------------------------
	// State
	// ---------------------------------------------------------------
	sse_pkg::state_t state_q;

	logic [sse_pkg::CFG_W-1:0]        active_count_q;
	logic [sse_pkg::VAL_W-1:0]        counters_q [sse_pkg::SET_SIZE];
	logic [sse_pkg::JFILL_W-1:0]      fill_q;
	logic                             batch_failed_q;

	// latched item
	logic [1:0]                       mode_q;
	logic [sse_pkg::IDX_W-1:0]        idx_q;
	logic signed [sse_pkg::OPV_W-1:0] opv_q;
	logic                             last_q;

	// result parked while undo runs or the output slot is busy
	logic [2:0]                       res_status_q;
	logic [sse_pkg::VAL_W-1:0]        res_value_q;
	logic                             res_done_q;

	// output register
	logic                             out_valid_q;
	logic [2:0]                       status_q;
	logic [sse_pkg::VAL_W-1:0]        value_q;
	logic                             batch_done_q;

	// ---------------------------------------------------------------
	// Journal RAM: {index, raw delta} per successful op of the batch
	// ---------------------------------------------------------------
	logic                             jr_we;
	logic [sse_pkg::JIDX_W-1:0]       jr_raddr;
	logic [sse_pkg::JE_W-1:0]         jr_wdata;
	logic [sse_pkg::JE_W-1:0]         jr_rdata;
	logic [sse_pkg::IDX_W-1:0]        j_idx;
	logic signed [sse_pkg::OPV_W-1:0] j_delta;
	logic                             j_idx_ok;

	assign jr_wdata = {idx_q, opv_q};
	assign jr_raddr = sse_pkg::JIDX_W'(fill_q - 1'b1);
	assign j_idx    = jr_rdata[sse_pkg::JE_W-1:sse_pkg::OPV_W];
	assign j_delta  = signed'(jr_rdata[sse_pkg::OPV_W-1:0]);
	assign j_idx_ok = {1'b0, j_idx} < sse_pkg::SET_LIMIT;

	sse_ram #(
		.WIDTH(sse_pkg::JE_W),
		.DEPTH(sse_pkg::JOURNAL_DEPTH)
	) u_journal (
		.clk  (clk),
		.we   (jr_we),
		.waddr(fill_q[sse_pkg::JIDX_W-1:0]),
		.wdata(jr_wdata),
		.raddr(jr_raddr),
		.rdata(jr_rdata)
	);

	// ---------------------------------------------------------------
	// Shared adder: item delta in EXEC, reversed journal delta in undo
	// ---------------------------------------------------------------
	logic [sse_pkg::IDX_W-1:0]        rd_idx;
	logic [sse_pkg::VAL_W-1:0]        cur;
	logic signed [sse_pkg::OPV_W-1:0] alu_delta;
	logic                             alu_sub;
	sse_pkg::alu_res_t                alu_res;

	assign rd_idx    = (state_q == sse_pkg::S_UNDO_WB) ? j_idx : idx_q;
	assign cur       = counters_q[rd_idx];
	assign alu_sub   = (state_q == sse_pkg::S_UNDO_WB);
	assign alu_delta = (state_q == sse_pkg::S_UNDO_WB) ? j_delta : opv_q;

	sse_alu u_alu (
		.base (cur),
		.delta(alu_delta),
		.sub  (alu_sub),
		.res  (alu_res)
	);

	// ---------------------------------------------------------------
	// Item decode (meaningful in EXEC)
	// ---------------------------------------------------------------
	logic                      idx_ok;
	logic [2:0]                ex_status;
	logic [sse_pkg::VAL_W-1:0] ex_value;
	logic                      ex_done;
	logic                      ex_fail;   // failure that aborts the batch
	logic                      ex_cnt_we;
	logic [sse_pkg::VAL_W-1:0] ex_cnt_val;
	logic                      slot_free;
	logic                      need_undo;

	assign idx_ok = ({1'b0, idx_q} < active_count_q) && ({1'b0, idx_q} < sse_pkg::SET_LIMIT);

	always_comb begin
		ex_status  = sse_pkg::ST_OK;
		ex_value   = '0;
		ex_done    = 1'b0;
		ex_cnt_we  = 1'b0;
		ex_cnt_val = alu_res.sat;
		case (mode_q)
			sse_pkg::MODE_OP: begin
				ex_done = last_q;
				if (batch_failed_q) begin
					ex_status = sse_pkg::ST_SKIPPED;
				end else if (!idx_ok) begin
					ex_status = sse_pkg::ST_BAD_INDEX;
				end else if (fill_q >= sse_pkg::FILL_LIMIT) begin
					ex_status = sse_pkg::ST_TOO_LONG;
				end else begin
					ex_value = cur;
					if (opv_q < 0) begin
						if (alu_res.under) ex_status = sse_pkg::ST_WOULD_BLOCK;
					end else if (opv_q > 0) begin
						if (alu_res.over) ex_status = sse_pkg::ST_OVERFLOW;
					end else if (cur != '0) begin
						ex_status = sse_pkg::ST_WOULD_BLOCK;
					end
					ex_cnt_we = (ex_status == sse_pkg::ST_OK);
				end
			end
			sse_pkg::MODE_SET: begin
				if (!idx_ok) begin
					ex_status = sse_pkg::ST_BAD_INDEX;
				end else if (opv_q[sse_pkg::OPV_W-1]) begin
					ex_status = sse_pkg::ST_NEG_SET;
				end else begin
					ex_value   = opv_q[sse_pkg::VAL_W-1:0];
					ex_cnt_we  = 1'b1;
					ex_cnt_val = opv_q[sse_pkg::VAL_W-1:0];
				end
			end
			default: begin
				// get, and the unused mode code
				if (!idx_ok) begin
					ex_status = sse_pkg::ST_BAD_INDEX;
				end else begin
					ex_value = cur;
				end
			end
		endcase
	end

	assign ex_fail   = (mode_q == sse_pkg::MODE_OP) && (ex_status != sse_pkg::ST_OK) &&
		(ex_status != sse_pkg::ST_SKIPPED);
	assign need_undo = ex_fail && (fill_q != '0);
	assign jr_we     = (state_q == sse_pkg::S_EXEC) && (mode_q == sse_pkg::MODE_OP) &&
		ex_cnt_we;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == sse_pkg::S_IDLE);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	logic out_load;
	logic from_res;

	always_comb begin
		out_load = 1'b0;
		from_res = 1'b0;
		case (state_q)
			sse_pkg::S_EXEC: out_load = !need_undo && slot_free;
			sse_pkg::S_FIN: begin
				out_load = slot_free;
				from_res = 1'b1;
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sse_pkg::S_IDLE;
			active_count_q <= sse_pkg::ACTIVE_RST;
			fill_q         <= '0;
			batch_failed_q <= 1'b0;
			out_valid_q    <= 1'b0;
			for (int i = 0; i < sse_pkg::SET_SIZE; i++) begin
				counters_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				active_count_q <= cfg_wdata;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				sse_pkg::S_IDLE: begin
					if (in_valid) begin
						state_q <= sse_pkg::S_EXEC;
					end
				end
				sse_pkg::S_EXEC: begin
					if (ex_cnt_we) begin
						counters_q[idx_q] <= ex_cnt_val;
					end
					if (mode_q == sse_pkg::MODE_OP) begin
						// closing item clears batch state; undo empties the journal
						batch_failed_q <= !last_q && (batch_failed_q || ex_fail);
						if (last_q && !need_undo) begin
							fill_q <= '0;
						end else if (ex_cnt_we) begin
							fill_q <= fill_q + 1'b1;
						end
					end
					if (need_undo) begin
						state_q <= sse_pkg::S_UNDO_RD;
					end else if (slot_free) begin
						state_q <= sse_pkg::S_IDLE;
					end else begin
						state_q <= sse_pkg::S_FIN;
					end
				end
				sse_pkg::S_UNDO_RD: begin
					fill_q  <= fill_q - 1'b1;
					state_q <= sse_pkg::S_UNDO_WB;
				end
				sse_pkg::S_UNDO_WB: begin
					if (j_idx_ok) begin
						counters_q[j_idx] <= alu_res.sat;
					end
					state_q <= (fill_q == '0) ? sse_pkg::S_FIN : sse_pkg::S_UNDO_RD;
				end
				sse_pkg::S_FIN: begin
					if (slot_free) begin
						state_q <= sse_pkg::S_IDLE;
					end
				end
				default: state_q <= sse_pkg::S_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			idx_q  <= sem_index;
			opv_q  <= op_value;
			last_q <= last_of_batch;
		end
		if (state_q == sse_pkg::S_EXEC) begin
			res_status_q <= ex_status;
			res_value_q  <= ex_value;
			res_done_q   <= ex_done;
		end
		if (out_load) begin
			status_q     <= from_res ? res_status_q : ex_status;
			value_q      <= from_res ? res_value_q : ex_value;
			batch_done_q <= from_res ? res_done_q : ex_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign value      = value_q;
	assign batch_done = batch_done_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= sse_pkg::FILL_LIMIT)
		else $error("journal fill beyond batch limit");

	a_failed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(batch_failed_q && state_q == sse_pkg::S_IDLE) |-> (fill_q == '0))
		else $error("failed batch left journal entries");

	a_undo_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sse_pkg::S_UNDO_RD) |=> (fill_q == $past(fill_q) - 1'b1))
		else $error("undo did not pop one journal entry");

	a_undo_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sse_pkg::S_UNDO_RD || state_q == sse_pkg::S_UNDO_WB) |-> !out_load)
		else $error("result delivered before undo finished");

endmodule
`default_nettype wire

[hdl/sse_ram.sv]
// sse_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the undo journal.
`timescale 1ns / 1ps
`default_nettype none
module sse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/sse_alu.sv]
// sse_alu: the one shared add/subtract unit with range flags and clamping.
// Depends on sse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sse_alu (
	input  wire logic [sse_pkg::VAL_W-1:0]        base,
	input  wire logic signed [sse_pkg::OPV_W-1:0] delta,
	input  wire logic                             sub,
	output sse_pkg::alu_res_t                     res
);

	localparam int SUM_W = sse_pkg::OPV_W + 2;

	logic signed [SUM_W-1:0] a_ext;
	logic signed [SUM_W-1:0] d_ext;
	logic signed [SUM_W-1:0] sum;

	assign a_ext = signed'({{(SUM_W-sse_pkg::VAL_W){1'b0}}, base});
	assign d_ext = signed'({{(SUM_W-sse_pkg::OPV_W){delta[sse_pkg::OPV_W-1]}}, delta});
	assign sum   = sub ? (a_ext - d_ext) : (a_ext + d_ext);

	always_comb begin
		res.under = sum[SUM_W-1];
		res.over  = !sum[SUM_W-1] && (|sum[SUM_W-2:sse_pkg::VAL_W]);
		if (res.under) begin
			res.sat = '0;
		end else if (res.over) begin
			res.sat = sse_pkg::COUNTER_MAX;
		end else begin
			res.sat = sum[sse_pkg::VAL_W-1:0];
		end
	end

endmodule
`default_nettype wire
